// ===== rtl/core/spt_pkg.sv =====
// shared constants, types and command/status structs for the sensor pairing table
// no dependencies

package spt_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int SLOT_W  = 5;
	localparam int BYTE_W  = 8;
	localparam int CODE_W  = 3 * BYTE_W;
	localparam int WORD_W  = CODE_W + 2 * BYTE_W;
	localparam int KEY_LSB = 3 * BYTE_W;

	typedef enum logic [1:0] {
		OUT_PAIRED  = 2'd0,
		OUT_ADDED   = 2'd1,
		OUT_FULL    = 2'd2,
		OUT_CLEARED = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic     load_req;
		logic     clear_valid;
		logic     scan_start;
		logic     scan_run;
		logic     write_entry;
		logic     load_out;
		outcome_t outcome;
	} cmd_t;

	typedef struct packed {
		logic cmp_hit;
		logic cmp_last;
		logic free_found;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/core/sensor_pairing_table.sv =====
// top level of the sensor pairing table: controller plus datapath
// depends on spt_pkg, spt_ctrl, spt_datapath (and spt_ram below it)
//
// channel   direction  handshake             payload
// request   in         in_valid / in_stall   operation, code_byte0..2, sensor_type, zone_kind
// result    out        out_valid / out_stall slot_index, outcome
//
// a clear goes from accept to the finish state and the result beat; an add scans the entry ram one slot
// per cycle through its registered read port and stops on a match, on a full table, or after the last
// slot with a write into the lowest free slot. one request is in work at a time.
// reset clears all valid bits at once; stored entries keep no reset value.
// the result register lets a new request in while the previous beat is still stalled.

module sensor_pairing_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       operation,
	input  logic [spt_pkg::BYTE_W-1:0] code_byte0,
	input  logic [spt_pkg::BYTE_W-1:0] code_byte1,
	input  logic [spt_pkg::BYTE_W-1:0] code_byte2,
	input  logic [spt_pkg::BYTE_W-1:0] sensor_type,
	input  logic [spt_pkg::BYTE_W-1:0] zone_kind,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [spt_pkg::SLOT_W-1:0] slot_index,
	output logic [1:0]                 outcome
);

	spt_pkg::cmd_t cmd;
	spt_pkg::sts_t sts;

	spt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.operation(operation),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	spt_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_byte0 (code_byte0),
		.code_byte1 (code_byte1),
		.code_byte2 (code_byte2),
		.sensor_type(sensor_type),
		.zone_kind  (zone_kind),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_index (slot_index),
		.outcome    (outcome)
	);

endmodule

// ===== rtl/core/spt_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies

module spt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/spt_ctrl.sv =====
// controller state machine: accept, scan, allocate, deliver
// depends on spt_pkg

module spt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          operation,
	output logic          in_stall,
	input  spt_pkg::sts_t sts,
	output spt_pkg::cmd_t cmd
);

	spt_pkg::state_t   state_q, state_nxt;
	spt_pkg::outcome_t outcome_q, outcome_nxt;

	always_comb begin
		state_nxt   = state_q;
		outcome_nxt = outcome_q;
		unique case (state_q)
			spt_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (operation) begin
						state_nxt   = spt_pkg::ST_FINISH;
						outcome_nxt = spt_pkg::OUT_CLEARED;
					end else begin
						state_nxt = spt_pkg::ST_SCAN;
					end
				end
			end
			spt_pkg::ST_SCAN: begin
				if (sts.cmp_hit) begin
					state_nxt   = spt_pkg::ST_FINISH;
					outcome_nxt = spt_pkg::OUT_PAIRED;
				end else if (sts.cmp_last) begin
					if (sts.free_found) begin
						state_nxt = spt_pkg::ST_WRITE;
					end else begin
						state_nxt   = spt_pkg::ST_FINISH;
						outcome_nxt = spt_pkg::OUT_FULL;
					end
				end
			end
			spt_pkg::ST_WRITE: begin
				state_nxt   = spt_pkg::ST_FINISH;
				outcome_nxt = spt_pkg::OUT_ADDED;
			end
			spt_pkg::ST_FINISH: begin
				if (!sts.out_busy) begin
					state_nxt = spt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = spt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.outcome = outcome_q;
		in_stall = 1'b1;
		unique case (state_q)
			spt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_req    = 1'b1;
					cmd.clear_valid = operation;
					cmd.scan_start  = !operation;
				end
			end
			spt_pkg::ST_SCAN: begin
				cmd.scan_run = 1'b1;
			end
			spt_pkg::ST_WRITE: begin
				cmd.write_entry = 1'b1;
			end
			spt_pkg::ST_FINISH: begin
				cmd.load_out = !sts.out_busy;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= spt_pkg::ST_IDLE;
			outcome_q <= spt_pkg::OUT_PAIRED;
		end else begin
			state_q   <= state_nxt;
			outcome_q <= outcome_nxt;
		end
	end

endmodule

// ===== rtl/core/spt_datapath.sv =====
// datapath: request register, valid bits, entry ram, scan pipeline, result register
// depends on spt_pkg and spt_ram

module spt_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [spt_pkg::BYTE_W-1:0]      code_byte0,
	input  logic [spt_pkg::BYTE_W-1:0]      code_byte1,
	input  logic [spt_pkg::BYTE_W-1:0]      code_byte2,
	input  logic [spt_pkg::BYTE_W-1:0]      sensor_type,
	input  logic [spt_pkg::BYTE_W-1:0]      zone_kind,
	input  spt_pkg::cmd_t                   cmd,
	output spt_pkg::sts_t                   sts,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [spt_pkg::SLOT_W-1:0]      slot_index,
	output logic [1:0]                      outcome
);

	logic [spt_pkg::WORD_W-1:0]  req_word_q;
	logic [spt_pkg::ENTRIES-1:0] valid_q;
	logic [spt_pkg::CNT_W-1:0]   iss_cnt_q;
	logic                        cmp_vld_s1;
	logic [spt_pkg::IDX_W-1:0]   cmp_idx_s1;
	logic                        free_q;
	logic [spt_pkg::IDX_W-1:0]   free_idx_q;
	logic [spt_pkg::IDX_W-1:0]   match_idx_q;
	logic                        out_valid_q;
	logic [spt_pkg::SLOT_W-1:0]  slot_q;
	logic [1:0]                  outcome_q;

	logic                        issue;
	logic [spt_pkg::IDX_W-1:0]   rd_addr;
	logic [spt_pkg::WORD_W-1:0]  rd_word;
	logic                        cmp_on;
	logic                        cmp_valid_bit;
	logic                        hit;
	logic [spt_pkg::IDX_W-1:0]   sel_idx;
	logic [spt_pkg::SLOT_W+spt_pkg::IDX_W-1:0] slot_ext;

	// word layout: code byte2, byte1, byte0, then sensor type, then zone
	assign issue   = cmd.scan_run && (iss_cnt_q < spt_pkg::CNT_W'(spt_pkg::ENTRIES));
	assign rd_addr = iss_cnt_q[spt_pkg::IDX_W-1:0];

	spt_ram #(
		.WIDTH(spt_pkg::WORD_W),
		.DEPTH(spt_pkg::ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (cmd.write_entry),
		.waddr(free_idx_q),
		.wdata(req_word_q),
		.re   (issue),
		.raddr(rd_addr),
		.rdata(rd_word)
	);

	assign cmp_on        = cmd.scan_run && cmp_vld_s1;
	assign cmp_valid_bit = valid_q[cmp_idx_s1];
	assign hit = cmp_on && cmp_valid_bit &&
		(rd_word[spt_pkg::WORD_W-1:spt_pkg::KEY_LSB] ==
		 req_word_q[spt_pkg::WORD_W-1:spt_pkg::KEY_LSB]);

	always_comb begin
		sts.cmp_hit    = hit;
		sts.cmp_last   = cmp_on && (cmp_idx_s1 == spt_pkg::IDX_W'(spt_pkg::ENTRIES - 1));
		sts.free_found = free_q || (cmp_on && !cmp_valid_bit);
		sts.out_busy   = out_valid_q && out_stall;
	end

	always_comb begin
		case (cmd.outcome)
			spt_pkg::OUT_PAIRED: sel_idx = match_idx_q;
			spt_pkg::OUT_ADDED:  sel_idx = free_idx_q;
			default:             sel_idx = '0;
		endcase
	end

	// low bits of the slot number, zero extended when the table is small
	assign slot_ext = {{spt_pkg::SLOT_W{1'b0}}, sel_idx};

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_word_q <= {code_byte2, code_byte1, code_byte0, sensor_type, zone_kind};
		end
		cmp_idx_s1 <= rd_addr;
		if (cmp_on && !cmp_valid_bit && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (hit) begin
			match_idx_q <= cmp_idx_s1;
		end
		if (cmd.load_out) begin
			slot_q    <= slot_ext[spt_pkg::SLOT_W-1:0];
			outcome_q <= cmd.outcome;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			iss_cnt_q   <= '0;
			cmp_vld_s1  <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_valid) begin
				valid_q <= '0;
			end else if (cmd.write_entry) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (cmd.scan_start) begin
				iss_cnt_q  <= '0;
				cmp_vld_s1 <= 1'b0;
				free_q     <= 1'b0;
			end else begin
				if (issue) begin
					iss_cnt_q <= iss_cnt_q + 1'b1;
				end
				cmp_vld_s1 <= issue;
				if (cmp_on && !cmp_valid_bit) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_index = slot_q;
	assign outcome    = outcome_q;

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_entry |-> free_q && !valid_q[free_idx_q])
		else $error("allocation into a slot that is not free");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> valid_q[cmp_idx_s1])
		else $error("match reported on an invalid slot");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_valid |=> valid_q == '0)
		else $error("valid bits not cleared");

	a_write_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_entry |-> $past(cmd.scan_run))
		else $error("entry written without a completed scan");

endmodule

// ===== dv/tb_sensor_pairing_table.sv =====
// testbench for sensor_pairing_table: random and directed add/clear requests under idling
// depends on spt_pkg and the sensor_pairing_table rtl; predicts each result in place

`timescale 1ns / 1ps

module tb_sensor_pairing_table;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;
	localparam int   POOL_N   = 48;
	localparam int   STALL_LIMIT = 50 * (spt_pkg::ENTRIES + 4);

	typedef struct packed {
		logic [spt_pkg::SLOT_W-1:0] slot;
		spt_pkg::outcome_t          outcome;
	} pair_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       operation;
	logic [spt_pkg::BYTE_W-1:0] code_byte0;
	logic [spt_pkg::BYTE_W-1:0] code_byte1;
	logic [spt_pkg::BYTE_W-1:0] code_byte2;
	logic [spt_pkg::BYTE_W-1:0] sensor_type;
	logic [spt_pkg::BYTE_W-1:0] zone_kind;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [spt_pkg::SLOT_W-1:0] slot_index;
	logic [1:0]                 outcome;

	// shadow copy of the pairing table
	bit                         slot_used [spt_pkg::ENTRIES];
	logic [spt_pkg::CODE_W-1:0] slot_code [spt_pkg::ENTRIES];
	logic [spt_pkg::BYTE_W-1:0] slot_kind [spt_pkg::ENTRIES];
	logic [spt_pkg::BYTE_W-1:0] slot_zone [spt_pkg::ENTRIES];

	pair_result_t pending_results[$];
	int           mismatches = 0;
	int           requests_sent;
	int           n_paired = 0;
	int           n_added = 0;
	int           n_full = 0;
	int           n_cleared = 0;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           quiet_cycles = 0;

	sensor_pairing_table u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.code_byte0  (code_byte0),
		.code_byte1  (code_byte1),
		.code_byte2  (code_byte2),
		.sensor_type (sensor_type),
		.zone_kind   (zone_kind),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.slot_index  (slot_index),
		.outcome     (outcome)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic pair_result_t pair_lookup(input logic op,
			input logic [spt_pkg::BYTE_W-1:0] b0,
			input logic [spt_pkg::BYTE_W-1:0] b1, input logic [spt_pkg::BYTE_W-1:0] b2,
			input logic [spt_pkg::BYTE_W-1:0] kind, input logic [spt_pkg::BYTE_W-1:0] zone);
		pair_result_t res;
		bit           done;
		res  = '{slot: '0, outcome: spt_pkg::OUT_FULL};
		done = 0;
		if (op == OP_CLEAR) begin
			for (int i = 0; i < spt_pkg::ENTRIES; i++)
				slot_used[i] = 0;
			res.outcome = spt_pkg::OUT_CLEARED;
			return res;
		end
		// lowest valid slot with equal bytes 1 and 2 wins
		for (int i = 0; i < spt_pkg::ENTRIES; i++) begin
			if (!done && slot_used[i] &&
					slot_code[i][spt_pkg::CODE_W-1:spt_pkg::BYTE_W] == {b2, b1}) begin
				res  = '{slot: i[spt_pkg::SLOT_W-1:0], outcome: spt_pkg::OUT_PAIRED};
				done = 1;
			end
		end
		for (int i = 0; i < spt_pkg::ENTRIES; i++) begin
			if (!done && !slot_used[i]) begin
				slot_used[i] = 1;
				slot_code[i] = {b2, b1, b0};
				slot_kind[i] = kind;
				slot_zone[i] = zone;
				res  = '{slot: i[spt_pkg::SLOT_W-1:0], outcome: spt_pkg::OUT_ADDED};
				done = 1;
			end
		end
		return res;
	endfunction

	task automatic issue_request(input logic op, input logic [spt_pkg::BYTE_W-1:0] b0,
			input logic [spt_pkg::BYTE_W-1:0] b1, input logic [spt_pkg::BYTE_W-1:0] b2,
			input logic [spt_pkg::BYTE_W-1:0] kind, input logic [spt_pkg::BYTE_W-1:0] zone);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		code_byte0  <= b0;
		code_byte1  <= b1;
		code_byte2  <= b2;
		sensor_type <= kind;
		zone_kind   <= zone;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(pair_lookup(op, b0, b1, b2, kind, zone));
		requests_sent++;
	endtask

	task automatic test_basic_pairing();
		issue_request(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		issue_request(OP_ADD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		// byte 0 differs, still the same sensor
		issue_request(OP_ADD, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF);
		issue_request(OP_ADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		issue_request(OP_ADD, 8'h5A, 8'hFF, 8'h00, 8'h01, 8'h80);
		issue_request(OP_ADD, 8'hA5, 8'h00, 8'hFF, 8'h80, 8'h01);
		issue_request(OP_ADD, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00);
		issue_request(OP_ADD, 8'h12, 8'hFF, 8'h00, 8'h34, 8'h56);
		issue_request(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// a cleared code must be allocated again from slot 0
		issue_request(OP_ADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		issue_request(OP_ADD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		issue_request(OP_ADD, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00);
		issue_request(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_table_full();
		logic [spt_pkg::BYTE_W-1:0] first_b1;
		logic [spt_pkg::BYTE_W-1:0] last_b1;
		first_b1 = 8'($urandom);
		for (int i = 0; i < spt_pkg::ENTRIES; i++) begin
			last_b1 = (i == 0) ? first_b1 : 8'($urandom);
			issue_request(OP_ADD, 8'($urandom), last_b1, 8'(i + 8'h40), 8'($urandom),
				8'($urandom));
		end
		issue_request(OP_ADD, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		issue_request(OP_ADD, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
		// lookups still hit while full
		issue_request(OP_ADD, 8'($urandom), last_b1, 8'(spt_pkg::ENTRIES - 1 + 8'h40),
			8'($urandom), 8'($urandom));
		issue_request(OP_ADD, 8'($urandom), first_b1, 8'h40, 8'($urandom), 8'($urandom));
		issue_request(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
		logic [2*spt_pkg::BYTE_W-1:0] key_pool [POOL_N];
		logic [2*spt_pkg::BYTE_W-1:0] key;
		int                           pick;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < POOL_N; i++)
			key_pool[i] = 16'($urandom);
		for (int n = 0; n < n_items; n++) begin
			pick = $urandom_range(99);
			if (pick < 2) begin
				issue_request(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
				if ($urandom_range(3) == 0)
					for (int i = 0; i < POOL_N; i++)
						key_pool[i] = 16'($urandom);
			end else begin
				key = (pick < 9) ? 16'($urandom) : key_pool[$urandom_range(POOL_N - 1)];
				issue_request(OP_ADD, 8'($urandom), key[7:0], key[15:8], 8'($urandom),
					8'($urandom));
			end
		end
	endtask

	// result side: random stall and compare against the oldest prediction
	always @(posedge clk) begin
		pair_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			case (spt_pkg::outcome_t'(outcome))
				spt_pkg::OUT_PAIRED:  n_paired++;
				spt_pkg::OUT_ADDED:   n_added++;
				spt_pkg::OUT_FULL:    n_full++;
				spt_pkg::OUT_CLEARED: n_cleared++;
				default:              mismatches++;
			endcase
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat slot_index=%0d outcome=%0d",
					$time, slot_index, outcome);
			end else begin
				want = pending_results.pop_front();
				if (slot_index !== want.slot) begin
					mismatches++;
					$display("%0t: slot_index expected %0d actual %0d",
						$time, want.slot, slot_index);
				end
				if (outcome !== want.outcome) begin
					mismatches++;
					$display("%0t: outcome expected %s actual %0d",
						$time, want.outcome.name(), outcome);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout at %0t with %0d results outstanding",
					$time, pending_results.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		operation     = OP_ADD;
		code_byte0    = '0;
		code_byte1    = '0;
		code_byte2    = '0;
		sensor_type   = '0;
		zone_kind     = '0;
		requests_sent = 0;
		send_idle_pct = 24;
		recv_idle_pct = 63;
		for (int i = 0; i < spt_pkg::ENTRIES; i++) begin
			slot_used[i] = 0;
			slot_code[i] = '0;
			slot_kind[i] = '0;
			slot_zone[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_pairing();
		test_table_full();
		test_random_traffic(600, 24, 63);
		test_random_traffic(600, 63, 24);
		test_random_traffic(600, 0, 0);
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (spt_pkg::ENTRIES + 8) @(posedge clk);

		$display("sent %0d requests under three idling mixes", requests_sent);
		$display("results seen: %0d paired, %0d added, %0d full, %0d cleared",
			n_paired, n_added, n_full, n_cleared);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results never arrived",
				mismatches, pending_results.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
